>>> hw/rtl/tets_pkg.sv
// ----------------------------------------------------------------------------
// tets_pkg
// Shared types and constants for the timed event table scheduler.
// ----------------------------------------------------------------------------
package tets_pkg;

   localparam int TABLE_SLOTS = 32;
   localparam int CONTACTS    = 64;
   localparam int SLOT_W      = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
   localparam int CNT_W       = $clog2(TABLE_SLOTS + 1);

   localparam logic [15:0] NO_TARGET    = 16'hFFFF;
   localparam logic [31:0] MS_PER_TENTH = 32'd100;
   localparam logic [3:0]  KIND_WAIT    = 4'd4;

   localparam logic [1:0] REQ_ADD     = 2'd0;
   localparam logic [1:0] REQ_TICK    = 2'd1;
   localparam logic [1:0] REQ_DELETE  = 2'd2;
   localparam logic [1:0] REQ_CONTACT = 2'd3;

   localparam logic [1:0] ACT_FIRE     = 2'd0;
   localparam logic [1:0] ACT_HOLD     = 2'd1;
   localparam logic [1:0] ACT_RELEASE  = 2'd2;
   localparam logic [1:0] ACT_REL_SPD  = 2'd3;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [15:0] delay_tenths;
      logic [3:0]  event_kind;
      logic [15:0] target_index;
      logic [7:0]  arg_a;
      logic [7:0]  arg_b;
      logic [15:0] ramp_tenths;
      logic [5:0]  contact_index;
      logic        contact_occupied;
   } req_word_type;

   typedef struct packed {
      logic [1:0]  out_action;
      logic [3:0]  out_kind;
      logic [15:0] out_target;
      logic [7:0]  out_arg_a;
      logic [7:0]  out_arg_b;
      logic [15:0] out_ramp;
      logic [5:0]  out_slot;
      logic        out_last;
   } rsp_word_type;

   // one table entry as held in the slot memory
   typedef struct packed {
      logic [31:0] deadline;
      logic [15:0] delay;
      logic [3:0]  kind;
      logic [15:0] target;
      logic [37:0] args;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

>>> hw/rtl/tets_ram.sv
// ----------------------------------------------------------------------------
// tets_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ----------------------------------------------------------------------------
module tets_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

>>> hw/rtl/timed_event_table_scheduler.sv
// ----------------------------------------------------------------------------
// timed_event_table_scheduler
// Table of delayed actions held in a slot RAM, scanned one slot per cycle.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | word
//  req_    | in        | req_valid/req_ready | req_word_type
//  rsp_    | out       | rsp_valid/rsp_ready | rsp_word_type
//
// Add, tick and delete scan the slot RAM once before the next request is
// accepted, and the scan waits while a full result register holds it. Contact
// updates and adds to a full table are done without a scan.
// The slot RAM read port sets the pace.
// Reset clears valid bits, slot count, time and contact map; RAM contents
// are never read before written. A stalled result holds the scan.
module timed_event_table_scheduler
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  tets_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tets_pkg::rsp_word_type rsp_word
);
   import tets_pkg::*;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_SCAN = 3'b010,
      ST_DONE = 3'b100
   } state_type;

   state_type            state_ff, state_in;
   req_word_type         req_ff, req_in;
   logic [TABLE_SLOTS-1:0] valid_ff, valid_in;
   logic [CNT_W-1:0]     used_ff, used_in;
   logic [31:0]          now_ff, now_in;
   logic [CONTACTS-1:0]  cmap_ff, cmap_in;
   logic [SLOT_W:0]      rd_ptr_ff, rd_ptr_in;   // address issued
   logic [SLOT_W:0]      ex_ptr_ff, ex_ptr_in;   // slot whose data is back
   logic                 ex_vld_ff, ex_vld_in;
   logic                 hit_ff, hit_in, free_ff, free_in, del_ff, del_in;
   logic [SLOT_W-1:0]    hit_slot_ff, hit_slot_in, free_slot_ff, free_slot_in;
   rsp_word_type         hold_ff, hold_in;       // result awaiting last flag
   logic                 hold_vld_ff, hold_vld_in;
   rsp_word_type         out_ff, out_in;
   logic                 out_vld_ff, out_vld_in;

   logic                 wr_en;
   logic [SLOT_W-1:0]    wr_addr, rd_addr, ex_slot;
   entry_type            wr_data, rd_data;
   logic [31:0]          add_deadline;
   logic [31:0]          age;
   logic [37:0]          req_args;
   logic                 stall, out_free;

   tets_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_SLOTS)) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_ready = (state_ff == ST_IDLE);
   assign rsp_valid = out_vld_ff;
   assign rsp_word  = out_ff;
   assign ex_slot   = ex_ptr_ff[SLOT_W-1:0];
   // re-read the slot under examination while stalled so its data stays put
   assign rd_addr   = stall ? ex_slot : rd_ptr_ff[SLOT_W-1:0];
   assign req_args  = {req_ff.contact_index, req_ff.ramp_tenths, req_ff.arg_b,
                       req_ff.arg_a};
   assign add_deadline = now_ff + MS_PER_TENTH * {16'd0, req_ff.delay_tenths};
   assign age       = now_ff - rd_data.deadline;
   assign out_free  = !out_vld_ff || rsp_ready;
   // a held result plus a new one cannot both go out when register is busy
   assign stall     = hold_vld_ff && !out_free;

   // main sequencer
   always_comb begin
      logic [1:0]  act;
      logic        emit, remove, rearm, busy_c;
      rsp_word_type r;
      state_in     = state_ff;
      req_in       = req_ff;
      valid_in     = valid_ff;
      used_in      = used_ff;
      now_in       = now_ff;
      cmap_in      = cmap_ff;
      rd_ptr_in    = rd_ptr_ff;
      ex_ptr_in    = ex_ptr_ff;
      ex_vld_in    = stall ? ex_vld_ff : 1'b0;
      hit_in       = hit_ff;
      free_in      = free_ff;
      del_in       = del_ff;
      hit_slot_in  = hit_slot_ff;
      free_slot_in = free_slot_ff;
      hold_in      = hold_ff;
      hold_vld_in  = hold_vld_ff;
      out_in       = out_ff;
      out_vld_in   = out_vld_ff && !rsp_ready;
      wr_en        = 1'b0;
      wr_addr      = ex_slot;
      wr_data      = rd_data;
      act          = ACT_FIRE;
      emit         = 1'b0;
      remove       = 1'b0;
      rearm        = 1'b0;
      busy_c       = 1'b0;
      r            = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               req_in       = req_word;
               rd_ptr_in    = '0;
               hit_in       = 1'b0;
               free_in      = 1'b0;
               del_in       = 1'b0;
               unique case (req_word.req_type)
                  REQ_CONTACT: begin
                     if (32'(req_word.contact_index) < CONTACTS) begin
                        cmap_in[req_word.contact_index] = req_word.contact_occupied;
                     end
                  end
                  REQ_ADD: begin
                     if (32'(used_ff) < TABLE_SLOTS) begin
                        state_in = ST_SCAN;
                     end
                  end
                  REQ_TICK: begin
                     now_in   = now_ff + 32'd1;
                     state_in = ST_SCAN;
                  end
                  default: begin
                     state_in = ST_SCAN;
                  end
               endcase
            end
         end
         ST_SCAN, ST_DONE: begin
            if (!stall) begin
               // issue next read
               if (state_ff == ST_SCAN) begin
                  ex_vld_in = 1'b1;
                  ex_ptr_in = rd_ptr_ff;
                  rd_ptr_in = rd_ptr_ff + 1'b1;
                  if (32'(rd_ptr_ff) == TABLE_SLOTS - 1) begin
                     state_in = ST_DONE;
                  end
               end
               // examine returned slot
               if (ex_vld_ff && valid_ff[ex_slot]) begin
                  unique case (req_ff.req_type)
                     REQ_ADD: begin
                        if (!hit_ff && rd_data.delay == req_ff.delay_tenths &&
                            rd_data.kind == req_ff.event_kind &&
                            rd_data.target == req_ff.target_index &&
                            rd_data.args == req_args) begin
                           hit_in      = 1'b1;
                           hit_slot_in = ex_slot;
                        end
                     end
                     REQ_TICK: begin
                        if (!age[31]) begin
                           if (rd_data.target == NO_TARGET) begin
                              remove = 1'b1;
                           end else if (rd_data.kind == KIND_WAIT) begin
                              busy_c = (32'(rd_data.args[37:32]) < CONTACTS) &&
                                       cmap_ff[rd_data.args[37:32]];
                              emit   = 1'b1;
                              if (busy_c) begin
                                 act   = ACT_HOLD;
                                 rearm = 1'b1;
                              end else begin
                                 act    = ACT_REL_SPD;
                                 remove = 1'b1;
                              end
                           end else begin
                              emit   = 1'b1;
                              remove = 1'b1;
                           end
                        end
                     end
                     REQ_DELETE: begin
                        if (!del_ff && rd_data.kind == KIND_WAIT &&
                            rd_data.target == req_ff.target_index) begin
                           del_in = 1'b1;
                           remove = 1'b1;
                           if (rd_data.target != NO_TARGET) begin
                              emit = 1'b1;
                              act  = ACT_RELEASE;
                           end
                        end
                     end
                     default: begin
                     end
                  endcase
               end else if (ex_vld_ff && req_ff.req_type == REQ_ADD && !free_ff) begin
                  free_in      = 1'b1;
                  free_slot_in = ex_slot;
               end
               if (rearm) begin
                  wr_en            = 1'b1;
                  wr_data.deadline = now_ff + MS_PER_TENTH;
               end
               if (remove) begin
                  valid_in[ex_slot] = 1'b0;
                  if (used_ff != '0) used_in = used_ff - 1'b1;
               end
               // results go through a one-word hold so the last flag is known
               if (emit) begin
                  r.out_action = act;
                  r.out_kind   = rd_data.kind;
                  r.out_target = rd_data.target;
                  r.out_arg_a  = rd_data.args[7:0];
                  r.out_arg_b  = rd_data.args[15:8];
                  r.out_ramp   = rd_data.args[31:16];
                  r.out_slot   = 6'(ex_slot);
                  r.out_last   = 1'b0;
                  if (hold_vld_ff) begin
                     out_in     = hold_ff;
                     out_vld_in = 1'b1;
                  end
                  hold_in     = r;
                  hold_vld_in = 1'b1;
               end
            end
            // scan finished: last examine done in an earlier cycle
            if (state_ff == ST_DONE && !ex_vld_ff && !ex_vld_in && !stall) begin
               if (req_ff.req_type == REQ_ADD && (hit_ff || free_ff)) begin
                  wr_en            = 1'b1;
                  wr_addr          = hit_ff ? hit_slot_ff : free_slot_ff;
                  wr_data.deadline = add_deadline;
                  wr_data.delay    = req_ff.delay_tenths;
                  wr_data.kind     = req_ff.event_kind;
                  wr_data.target   = req_ff.target_index;
                  wr_data.args     = req_args;
                  if (!hit_ff) begin
                     valid_in[free_slot_ff] = 1'b1;
                     used_in = used_ff + 1'b1;
                  end
               end
               if (hold_vld_ff) begin
                  out_in          = hold_ff;
                  out_in.out_last = 1'b1;
                  out_vld_in      = 1'b1;
                  hold_vld_in     = 1'b0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         valid_ff    <= '0;
         used_ff     <= '0;
         now_ff      <= '0;
         cmap_ff     <= '0;
         ex_vld_ff   <= 1'b0;
         hold_vld_ff <= 1'b0;
         out_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         valid_ff    <= valid_in;
         used_ff     <= used_in;
         now_ff      <= now_in;
         cmap_ff     <= cmap_in;
         ex_vld_ff   <= ex_vld_in;
         hold_vld_ff <= hold_vld_in;
         out_vld_ff  <= out_vld_in;
      end
      req_ff       <= req_in;
      rd_ptr_ff    <= rd_ptr_in;
      ex_ptr_ff    <= ex_ptr_in;
      hit_ff       <= hit_in;
      free_ff      <= free_in;
      del_ff       <= del_in;
      hit_slot_ff  <= hit_slot_in;
      free_slot_ff <= free_slot_in;
      hold_ff      <= hold_in;
      out_ff       <= out_in;
   end

   // slot count always agrees with the valid bits
   a_count: assert property (@(posedge clock) disable iff (reset)
      32'($countones(valid_ff)) == 32'(used_ff))
      else $error("slot count out of step with valid bits");

   // no word accepted while a scan runs
   a_idle: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !ex_vld_ff && !hold_vld_ff)
      else $error("accepting while scan state live");

   // a held result is never overwritten while the output is stalled
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (out_vld_ff && !rsp_ready) |=> $stable(out_ff))
      else $error("result register changed under stall");

   // time only moves on an accepted tick
   a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_valid && req_ready && req_word.req_type == REQ_TICK) |=> $stable(now_ff))
      else $error("time advanced without a tick");

endmodule

>>> bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the timed event table scheduler: directed and
// random adds, ticks, deletes and contact updates, with a predictive
// scoreboard of the slot table and random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
   import tets_pkg::*;

   // ------------------------------------------------------------------------
   // Scoreboard: shadow table and queue of expected result words
   // ------------------------------------------------------------------------
   class event_table_sb;
      bit          live [TABLE_SLOTS];
      bit [31:0]   due [TABLE_SLOTS];
      bit [15:0]   dly [TABLE_SLOTS];
      bit [3:0]    knd [TABLE_SLOTS];
      bit [15:0]   tgt [TABLE_SLOTS];
      bit [37:0]   arg [TABLE_SLOTS];
      int          used;
      bit [31:0]   now_ms;
      bit [63:0]   contacts;
      rsp_word_type pending [$];
      int          errors;

      function void emit_word(bit [1:0] act, int s);
         rsp_word_type w;
         w.out_action = act;
         w.out_kind   = knd[s];
         w.out_target = tgt[s];
         w.out_arg_a  = arg[s][7:0];
         w.out_arg_b  = arg[s][15:8];
         w.out_ramp   = arg[s][31:16];
         w.out_slot   = 6'(s);
         w.out_last   = 1'b0;
         pending.push_back(w);
      endfunction

      function void drop(int s);
         live[s] = 0;
         if (used > 0) used--;
      endfunction

      // note one accepted request word
      function void note_request(req_word_type r);
         int hit, free_s, base;
         bit [37:0] a;
         bit [5:0] c;
         base = pending.size();
         a = {r.contact_index, r.ramp_tenths, r.arg_b, r.arg_a};
         case (r.req_type)
            REQ_ADD: begin
               if (used < TABLE_SLOTS) begin
                  hit = -1; free_s = -1;
                  for (int s = 0; s < TABLE_SLOTS; s++) begin
                     if (!live[s]) begin
                        if (free_s < 0) free_s = s;
                     end else if (hit < 0 && dly[s] == r.delay_tenths &&
                                  knd[s] == r.event_kind &&
                                  tgt[s] == r.target_index && arg[s] == a) begin
                        hit = s;
                     end
                  end
                  if (hit < 0) hit = free_s;
                  if (hit >= 0) begin
                     if (!live[hit]) used++;
                     live[hit] = 1;
                     due[hit]  = now_ms + MS_PER_TENTH * 32'(r.delay_tenths);
                     dly[hit]  = r.delay_tenths;
                     knd[hit]  = r.event_kind;
                     tgt[hit]  = r.target_index;
                     arg[hit]  = a;
                  end
               end
            end
            REQ_TICK: begin
               now_ms++;
               for (int s = 0; s < TABLE_SLOTS; s++) begin
                  if (live[s] && !((now_ms - due[s]) >= 32'h8000_0000)) begin
                     if (tgt[s] == NO_TARGET) drop(s);
                     else if (knd[s] == KIND_WAIT) begin
                        c = arg[s][37:32];
                        if (int'(c) < CONTACTS && contacts[c]) begin
                           emit_word(ACT_HOLD, s);
                           due[s] = now_ms + MS_PER_TENTH;
                        end else begin
                           emit_word(ACT_REL_SPD, s);
                           drop(s);
                        end
                     end else begin
                        emit_word(ACT_FIRE, s);
                        drop(s);
                     end
                  end
               end
            end
            REQ_DELETE: begin
               for (int s = 0; s < TABLE_SLOTS; s++) begin
                  if (live[s] && knd[s] == KIND_WAIT && tgt[s] == r.target_index) begin
                     if (tgt[s] != NO_TARGET) emit_word(ACT_RELEASE, s);
                     drop(s);
                     break;
                  end
               end
            end
            default: begin
               if (int'(r.contact_index) < CONTACTS)
                  contacts[r.contact_index] = r.contact_occupied;
            end
         endcase
         if (pending.size() > base) pending[pending.size()-1].out_last = 1'b1;
      endfunction

      // compare one accepted result word with the oldest expectation
      function void check_result(rsp_word_type g);
         rsp_word_type e;
         if (pending.size() == 0) begin
            $error("unexpected result word %h", g);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (g.out_action !== e.out_action) begin
            $error("out_action exp %0d got %0d", e.out_action, g.out_action); errors++;
         end
         if (g.out_kind !== e.out_kind) begin
            $error("out_kind exp %0d got %0d", e.out_kind, g.out_kind); errors++;
         end
         if (g.out_target !== e.out_target) begin
            $error("out_target exp %0d got %0d", e.out_target, g.out_target); errors++;
         end
         if (g.out_arg_a !== e.out_arg_a) begin
            $error("out_arg_a exp %0d got %0d", e.out_arg_a, g.out_arg_a); errors++;
         end
         if (g.out_arg_b !== e.out_arg_b) begin
            $error("out_arg_b exp %0d got %0d", e.out_arg_b, g.out_arg_b); errors++;
         end
         if (g.out_ramp !== e.out_ramp) begin
            $error("out_ramp exp %0d got %0d", e.out_ramp, g.out_ramp); errors++;
         end
         if (g.out_slot !== e.out_slot) begin
            $error("out_slot exp %0d got %0d", e.out_slot, g.out_slot); errors++;
         end
         if (g.out_last !== e.out_last) begin
            $error("out_last exp %0d got %0d", e.out_last, g.out_last); errors++;
         end
      endfunction
   endclass

   logic         clock = 0;
   logic         reset = 1;
   logic         req_valid = 0;
   logic         req_ready;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_ready = 0;
   rsp_word_type rsp_word;

   event_table_sb sb = new();
   bit            stim_done = 0;
   int            hold_cycles = 0;

   timed_event_table_scheduler dut (.*);

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // ------------------------------------------------------------------------
   // Request driver
   // ------------------------------------------------------------------------
   task automatic send_word(req_word_type w);
      int gap;
      bit seen;
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word  <= w;
      // ready is sampled mid-cycle, where it is settled for the coming edge
      do begin
         @(negedge clock);
         seen = req_ready;
         @(posedge clock);
      end while (!seen);
      sb.note_request(w);
   endtask

   function automatic req_word_type rand_word();
      req_word_type w;
      logic [95:0]  raw;
      raw = {$urandom, $urandom, $urandom};
      w = raw[$bits(req_word_type)-1:0];
      return w;
   endfunction

   // well-formed add: short delays, reused keys so re-arming happens
   function automatic req_word_type rand_add();
      req_word_type w;
      w = rand_word();
      w.req_type = REQ_ADD;
      w.delay_tenths = ($urandom_range(0, 19) == 0) ? 16'($urandom) :
                       16'($urandom_range(0, 2));
      w.event_kind = ($urandom_range(0, 2) == 0) ? KIND_WAIT :
                     4'($urandom_range(0, 15));
      w.target_index = ($urandom_range(0, 9) == 0) ? NO_TARGET :
                       16'($urandom_range(0, 3));
      if ($urandom_range(0, 1)) begin
         w.arg_a = 8'($urandom_range(0, 1));
         w.arg_b = 0;
         w.ramp_tenths = 0;
      end
      w.contact_index = 6'($urandom_range(0, 3));
      return w;
   endfunction

   function automatic req_word_type mk(bit [1:0] t, bit [15:0] d, bit [3:0] k,
                                       bit [15:0] g, bit [5:0] c, bit occ);
      req_word_type w;
      w = rand_word();
      w.req_type = t; w.delay_tenths = d; w.event_kind = k;
      w.target_index = g; w.contact_index = c; w.contact_occupied = occ;
      return w;
   endfunction

   task automatic tick_n(int n);
      repeat (n) send_word(mk(REQ_TICK, 0, 0, 0, 0, 0));
   endtask

   initial begin
      req_word_type w;
      int pick;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every request type, special cases
      send_word(mk(REQ_ADD, 0, 0, 16'd0, 0, 0));
      send_word(mk(REQ_ADD, 0, KIND_WAIT, 16'd5, 6'd63, 0));
      send_word(mk(REQ_ADD, 0, 4'd15, NO_TARGET, 0, 0));
      send_word(mk(REQ_ADD, 1, 4'd8, 16'hFFFE, 0, 0));
      send_word(mk(REQ_CONTACT, 0, 0, 0, 6'd63, 1));
      send_word(mk(REQ_ADD, 0, KIND_WAIT, 16'd7, 6'd63, 0));
      tick_n(1);
      send_word(mk(REQ_CONTACT, 0, 0, 0, 6'd63, 0));
      send_word(mk(REQ_DELETE, 0, 0, 16'd5, 0, 0));
      send_word(mk(REQ_ADD, 16'hFFFF, KIND_WAIT, NO_TARGET, 0, 0));
      send_word(mk(REQ_DELETE, 0, 0, NO_TARGET, 0, 0));
      send_word(mk(REQ_DELETE, 0, 0, 16'd1234, 0, 0));
      tick_n(101);
      // fill the table beyond full, then drain by ticking
      for (int i = 0; i < TABLE_SLOTS + 2; i++)
         send_word(mk(REQ_ADD, 0, 4'(i % 9), 16'(i), 6'(i), 0));
      tick_n(1);

      // random: mostly adds and ticks, some deletes, contacts and noise
      for (int i = 0; i < 180; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 45) w = rand_add();
         else if (pick < 80) w = mk(REQ_TICK, 0, 0, 0, 0, 0);
         else if (pick < 88) w = mk(REQ_DELETE, 0, 0,
                                    ($urandom_range(0, 9) == 0) ? NO_TARGET :
                                    16'($urandom_range(0, 3)), 0, 0);
         else if (pick < 96) w = mk(REQ_CONTACT, 0, 0, 0,
                                    6'($urandom_range(0, 3)), 1'($urandom));
         else w = rand_word();
         send_word(w);
      end
      req_valid <= 1'b0;
      stim_done = 1;
   end

   // ------------------------------------------------------------------------
   // Result receiver, with one long hold-off to back the block up
   // ------------------------------------------------------------------------
   initial begin
      int gap;
      bit got;
      rsp_word_type word;
      @(negedge reset);
      forever begin
         if (hold_cycles == 0 && $urandom_range(0, 1999) == 0 || hold_cycles == 1) begin
            rsp_ready <= 1'b0;
            repeat (300) @(posedge clock);
            hold_cycles = 2;
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 4);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do begin
            @(negedge clock);
            got  = rsp_valid;
            word = rsp_word;
            @(posedge clock);
         end while (!got);
         sb.check_result(word);
         if (hold_cycles == 0) hold_cycles = 1;
      end
   end

   // ------------------------------------------------------------------------
   // End of run
   // ------------------------------------------------------------------------
   initial begin
      wait (stim_done);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #5ms;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
